/* sv/sfab_pkg.sv */
// ----------------------------------------------------------------------------
// sfab_pkg: shared types and constants of the seam feather alpha blend core
// Holds the input and result word layouts, the configuration register map and
// the fixed widths that every stage of the pipeline agrees on.
// ----------------------------------------------------------------------------
package sfab_pkg;

    localparam int POS_W      = 12;
    localparam int DIM_W      = 13;
    localparam int BAND_W     = 8;
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Largest region dimension honored; larger values are taken as this one.
    localparam int MAX_DIM = 4096;
    localparam logic [DIM_W-1:0] DIM_CAP =
        (MAX_DIM >= 8191) ? 13'h1FFF : 13'(MAX_DIM);

    // Quotient digits resolved by one stage of the weight divider.
    localparam int DIV_DIGITS_PER_STAGE = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_WIDTH  = 2'd0,
        CFG_REGION_HEIGHT = 2'd1,
        CFG_BLEND_BAND    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]  region_width;
        logic [DIM_W-1:0]  region_height;
        logic [BAND_W-1:0] blend_band;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] pixel_col;
        logic [POS_W-1:0] pixel_row;
        logic [CH_W-1:0]  tile_blue;
        logic [CH_W-1:0]  tile_green;
        logic [CH_W-1:0]  tile_red;
        logic [CH_W-1:0]  mosaic_blue;
        logic [CH_W-1:0]  mosaic_green;
        logic [CH_W-1:0]  mosaic_red;
    } pix_in_t;

    typedef struct packed {
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_red;
    } pix_out_t;

    // Per-pixel decisions made at the front of the pipeline.
    typedef struct packed {
        logic outside;  // position lies outside the region: keep mosaic
        logic copy;     // band of zero: copy tile
        logic full_x;   // horizontal weight is exactly one
        logic full_y;   // vertical weight is exactly one
    } flags_t;

    typedef struct packed {
        flags_t  flags;
        pix_in_t pix;
    } carry_t;

endpackage

/* sv/sfab_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sfab_cfg_regs: configuration register file
// Holds region width, region height and blend band; writes to indexes beyond
// the map are dropped.
// ----------------------------------------------------------------------------
module sfab_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [sfab_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [sfab_pkg::CFG_DATA_W-1:0]  wr_data,
    output sfab_pkg::cfg_t                   cfg
);

    sfab_pkg::cfg_t cfg_reg;
    sfab_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                sfab_pkg::CFG_REGION_WIDTH:  cfg_next.region_width  = wr_data;
                sfab_pkg::CFG_REGION_HEIGHT: cfg_next.region_height = wr_data;
                sfab_pkg::CFG_BLEND_BAND:    cfg_next.blend_band    =
                                                 wr_data[sfab_pkg::BAND_W-1:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_width  <= 13'd640;
            cfg_reg.region_height <= 13'd480;
            cfg_reg.blend_band    <= 8'd8;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/sfab_axis_div.sv */
// ----------------------------------------------------------------------------
// sfab_axis_div: pipelined ramp weight divider
// Computes (ramp_dist * 2^FRAC_BITS + band/2) / band for ramp_dist <= band,
// DIV_DIGITS_PER_STAGE restoring quotient digits per stage.
// ----------------------------------------------------------------------------
module sfab_axis_div
#(
    parameter int FRAC_BITS = 16,
    parameter int N_STAGES  = 4
)
(
    input  logic                         clk,
    input  logic [N_STAGES-1:0]          en,
    input  logic [sfab_pkg::BAND_W-1:0]  ramp_dist,
    input  logic [sfab_pkg::BAND_W-1:0]  band,
    output logic [FRAC_BITS:0]           quot
);

    localparam int DPS = sfab_pkg::DIV_DIGITS_PER_STAGE;
    localparam int BW  = sfab_pkg::BAND_W;

    logic [BW-1:0]      rem_reg  [N_STAGES];
    logic [FRAC_BITS:0] q_reg    [N_STAGES];
    logic [BW-1:0]      band_reg [N_STAGES-1];

    for (genvar s = 0; s < N_STAGES; s++)
    begin : g_stage
        localparam int FIRST = s * DPS;
        localparam int CNT   = ((FRAC_BITS - FIRST) < DPS) ? (FRAC_BITS - FIRST) : DPS;

        logic [BW-1:0]        rem_in;
        logic [FRAC_BITS:0]   q_in;
        logic [BW-1:0]        band_in;
        logic [BW-1:0]        rem_next;
        logic [FRAC_BITS:0]   q_next;
        logic [FRAC_BITS-1:0] half_bits;
        logic [BW:0]          trial;
        logic                 q_bit;

        if (s == 0)
        begin : g_head
            // Leading digit: ramp_dist never exceeds band, so it is one only on
            // equality.
            always_comb
            begin
                band_in = band;
                if (ramp_dist == band)
                begin
                    rem_in = '0;
                    q_in   = {{FRAC_BITS{1'b0}}, 1'b1};
                end
                else
                begin
                    rem_in = ramp_dist;
                    q_in   = '0;
                end
            end
        end
        else
        begin : g_body
            assign band_in = band_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign q_in    = q_reg[s-1];
        end

        // The low dividend bits are band/2, which provides the half-up rounding.
        always_comb
        begin
            half_bits = {{(FRAC_BITS-BW+1){1'b0}}, band_in[BW-1:1]} << FIRST;
            rem_next  = rem_in;
            q_next    = q_in;
            trial     = '0;
            q_bit     = 1'b0;
            for (int t = 0; t < CNT; t++)
            begin
                trial     = {rem_next, half_bits[FRAC_BITS-1]};
                half_bits = half_bits << 1;
                q_bit     = (trial >= {1'b0, band_in});
                if (q_bit)
                begin
                    trial = trial - {1'b0, band_in};
                end
                rem_next = trial[BW-1:0];
                q_next   = {q_next[FRAC_BITS-1:0], q_bit};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_next;
                q_reg[s]   <= q_next;
            end
        end

        if (s < N_STAGES - 1)
        begin : g_band
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    band_reg[s] <= band_in;
                end
            end
        end
    end

    assign quot = q_reg[N_STAGES-1];

endmodule

/* sv/sfab_blend_mix.sv */
// ----------------------------------------------------------------------------
// sfab_blend_mix: alpha select, channel products and final pixel
// Three register stages: smaller weight, the six unrounded products, and the
// rounded, saturated sum or pass-through pixel.
// ----------------------------------------------------------------------------
module sfab_blend_mix
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic [2:0]          en,
    input  sfab_pkg::carry_t    carry,
    input  logic [FRAC_BITS:0]  quot_x,
    input  logic [FRAC_BITS:0]  quot_y,
    output sfab_pkg::pix_out_t  result
);

    localparam int CW = sfab_pkg::CH_W;
    localparam int PW = FRAC_BITS + CW + 1;
    localparam logic [FRAC_BITS:0] ALPHA_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0]      ALPHA_HALF = PW'(1) << (FRAC_BITS - 1);

    sfab_pkg::carry_t   carry_a_reg;
    sfab_pkg::carry_t   carry_b_reg;
    logic [FRAC_BITS:0] alpha_reg;
    logic [FRAC_BITS:0] alpha_next;
    logic [PW-1:0]      pt_reg   [3];
    logic [PW-1:0]      pm_reg   [3];
    logic [CW-1:0]      tile_ch  [3];
    logic [CW-1:0]      mos_ch   [3];
    logic [CW-1:0]      mix_ch   [3];
    sfab_pkg::pix_out_t result_reg;
    sfab_pkg::pix_out_t result_next;

    always_comb
    begin
        logic [FRAC_BITS:0] ax;
        logic [FRAC_BITS:0] ay;
        ax = carry.flags.full_x ? ALPHA_ONE : quot_x;
        ay = carry.flags.full_y ? ALPHA_ONE : quot_y;
        alpha_next = (ay < ax) ? ay : ax;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            carry_a_reg <= carry;
            alpha_reg   <= alpha_next;
        end
    end

    assign tile_ch[0] = carry_a_reg.pix.tile_blue;
    assign tile_ch[1] = carry_a_reg.pix.tile_green;
    assign tile_ch[2] = carry_a_reg.pix.tile_red;
    assign mos_ch[0]  = carry_a_reg.pix.mosaic_blue;
    assign mos_ch[1]  = carry_a_reg.pix.mosaic_green;
    assign mos_ch[2]  = carry_a_reg.pix.mosaic_red;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            carry_b_reg <= carry_a_reg;
            for (int c = 0; c < 3; c++)
            begin
                pt_reg[c] <= PW'(alpha_reg) * PW'(tile_ch[c]);
                pm_reg[c] <= PW'(ALPHA_ONE - alpha_reg) * PW'(mos_ch[c]);
            end
        end
    end

    // Each product rounds half up on its own before the two are summed.
    always_comb
    begin
        logic [PW-1:0] rt;
        logic [PW-1:0] rm;
        logic [CW+1:0] sum;
        rt  = '0;
        rm  = '0;
        sum = '0;
        for (int c = 0; c < 3; c++)
        begin
            rt  = pt_reg[c] + ALPHA_HALF;
            rm  = pm_reg[c] + ALPHA_HALF;
            sum = {1'b0, rt[PW-1:FRAC_BITS]} + {1'b0, rm[PW-1:FRAC_BITS]};
            mix_ch[c] = (sum > (CW+2)'(255)) ? {CW{1'b1}} : sum[CW-1:0];
        end
    end

    always_comb
    begin
        if (carry_b_reg.flags.outside)
        begin
            result_next.out_blue  = carry_b_reg.pix.mosaic_blue;
            result_next.out_green = carry_b_reg.pix.mosaic_green;
            result_next.out_red   = carry_b_reg.pix.mosaic_red;
        end
        else if (carry_b_reg.flags.copy)
        begin
            result_next.out_blue  = carry_b_reg.pix.tile_blue;
            result_next.out_green = carry_b_reg.pix.tile_green;
            result_next.out_red   = carry_b_reg.pix.tile_red;
        end
        else
        begin
            result_next.out_blue  = mix_ch[0];
            result_next.out_green = mix_ch[1];
            result_next.out_red   = mix_ch[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* sv/seam_feather_alpha_blend_core.sv */
// ----------------------------------------------------------------------------
// seam_feather_alpha_blend_core: linear feather blend at right and bottom seams
// Blends each tile pixel into the mosaic pixel under it, with an alpha that
// ramps down linearly across the right and bottom blend bands of the region.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Word
//  --------  ----------------------  ---------------------------------------
//  pixel     pixel_valid/stall  in   position, tile BGR and mosaic BGR
//  result    result_valid/stall out  blended BGR
//  cfg       cfg_valid/ready    in   register index and write data
//
// The core takes one word per clock cycle unless the pipeline is full and the
// result side stalls. A front stage feeds N_DIV = ceil(ALPHA_FRAC_BITS / 4)
// stages of the weight divider, which resolves four quotient digits per stage.
// Reset clears every valid bit and loads width 640, height 480 and band 8.
// A stall on the result side holds the last stage; earlier stages keep moving
// until they meet a full stage, so bubbles are squeezed out and nothing is lost
// or repeated. The config port is always ready.
//
module seam_feather_alpha_blend_core
#(
    parameter int ALPHA_FRAC_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pixel_valid,
    output logic                              pixel_stall,
    input  sfab_pkg::pix_in_t                 pixel,
    output logic                              result_valid,
    input  logic                              result_stall,
    output sfab_pkg::pix_out_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfab_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sfab_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int F      = ALPHA_FRAC_BITS;
    localparam int DPS    = sfab_pkg::DIV_DIGITS_PER_STAGE;
    localparam int N_DIV  = (F + DPS - 1) / DPS;
    // Front stage, divider stages, then three mixing stages.
    localparam int N_TOT  = N_DIV + 4;
    localparam int DW     = sfab_pkg::DIM_W;
    localparam int BW     = sfab_pkg::BAND_W;

    sfab_pkg::cfg_t cfg;

    logic [N_TOT-1:0] valid_reg;
    logic [N_TOT-1:0] valid_next;
    logic [N_TOT:0]   ready;

    sfab_pkg::carry_t carry_reg [N_DIV+1];
    sfab_pkg::carry_t carry_next;

    logic [BW-1:0] dist_x_reg;
    logic [BW-1:0] dist_y_reg;
    logic [BW-1:0] band_x_reg;
    logic [BW-1:0] band_y_reg;
    logic [BW-1:0] dist_x_next;
    logic [BW-1:0] dist_y_next;
    logic [BW-1:0] band_x_next;
    logic [BW-1:0] band_y_next;

    logic [F:0] quot_x;
    logic [F:0] quot_y;

    assign cfg_ready = 1'b1;

    sfab_cfg_regs u_cfg_regs
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb
    begin
        ready[N_TOT] = !result_stall;
        for (int k = N_TOT - 1; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    always_comb
    begin
        for (int k = 0; k < N_TOT; k++)
        begin
            if (!ready[k])
            begin
                valid_next[k] = valid_reg[k];
            end
            else if (k == 0)
            begin
                valid_next[k] = pixel_valid;
            end
            else
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pixel_stall  = !ready[0];
    assign result_valid = valid_reg[N_TOT-1];

    // Front stage: clamp the region, size both bands, and decide which pixels
    // bypass the ramp. Inside the region, the distance to the far edge is at
    // least one, so a band of zero or a distance past the band means weight one.
    always_comb
    begin
        logic [DW-1:0]   w;
        logic [DW-1:0]   h;
        logic [DW-2:0]   half_w;
        logic [DW-2:0]   half_h;
        logic [DW-1:0]   dx;
        logic [DW-1:0]   dy;
        w      = (cfg.region_width  > sfab_pkg::DIM_CAP) ? sfab_pkg::DIM_CAP
                                                         : cfg.region_width;
        h      = (cfg.region_height > sfab_pkg::DIM_CAP) ? sfab_pkg::DIM_CAP
                                                         : cfg.region_height;
        half_w = w[DW-1:1];
        half_h = h[DW-1:1];
        band_x_next = ({{(DW-1-BW){1'b0}}, cfg.blend_band} < half_w) ? cfg.blend_band
                                                                     : half_w[BW-1:0];
        band_y_next = ({{(DW-1-BW){1'b0}}, cfg.blend_band} < half_h) ? cfg.blend_band
                                                                     : half_h[BW-1:0];
        dx = w - {1'b0, pixel.pixel_col};
        dy = h - {1'b0, pixel.pixel_row};
        dist_x_next = dx[BW-1:0];
        dist_y_next = dy[BW-1:0];

        carry_next.pix           = pixel;
        carry_next.flags.outside = ({1'b0, pixel.pixel_col} >= w) ||
                                   ({1'b0, pixel.pixel_row} >= h);
        carry_next.flags.copy    = (cfg.blend_band == '0);
        carry_next.flags.full_x  = (band_x_next == '0) ||
                                   (dx > {{(DW-BW){1'b0}}, band_x_next});
        carry_next.flags.full_y  = (band_y_next == '0) ||
                                   (dy > {{(DW-BW){1'b0}}, band_y_next});
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            carry_reg[0] <= carry_next;
            dist_x_reg   <= dist_x_next;
            dist_y_reg   <= dist_y_next;
            band_x_reg   <= band_x_next;
            band_y_reg   <= band_y_next;
        end
    end

    // The pixel and its flags ride alongside the divider stages.
    for (genvar k = 1; k <= N_DIV; k++)
    begin : g_carry
        always_ff @(posedge clk)
        begin
            if (ready[k])
            begin
                carry_reg[k] <= carry_reg[k-1];
            end
        end
    end

    sfab_axis_div
    #(
        .FRAC_BITS (F),
        .N_STAGES  (N_DIV)
    )
    u_div_x
    (
        .clk       (clk),
        .en        (ready[N_DIV:1]),
        .ramp_dist (dist_x_reg),
        .band      (band_x_reg),
        .quot      (quot_x)
    );

    sfab_axis_div
    #(
        .FRAC_BITS (F),
        .N_STAGES  (N_DIV)
    )
    u_div_y
    (
        .clk       (clk),
        .en        (ready[N_DIV:1]),
        .ramp_dist (dist_y_reg),
        .band      (band_y_reg),
        .quot      (quot_y)
    );

    sfab_blend_mix
    #(
        .FRAC_BITS (F)
    )
    u_mix
    (
        .clk    (clk),
        .en     (ready[N_DIV+3:N_DIV+1]),
        .carry  (carry_reg[N_DIV]),
        .quot_x (quot_x),
        .quot_y (quot_y),
        .result (result)
    );

endmodule

/* bench/sfab_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfab_checker: scoreboard for the seam feather alpha blend core
// Watches the pixel, result and register channels, keeps its own copy of the
// region registers, predicts each blended pixel and compares it on arrival.
// ----------------------------------------------------------------------------
module sfab_checker
#(
    parameter int ALPHA_FRAC_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            pixel_valid,
    input  logic                            pixel_stall,
    input  sfab_pkg::pix_in_t               pixel,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  sfab_pkg::pix_out_t              result,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sfab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sfab_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              fail_count,
    output int                              pending
);

    localparam longint unsigned ALPHA_ONE  = 64'd1 << ALPHA_FRAC_BITS;
    localparam longint unsigned ALPHA_HALF = 64'd1 << (ALPHA_FRAC_BITS - 1);
    localparam longint unsigned DIM_LIMIT  = 64'(sfab_pkg::MAX_DIM);

    localparam logic [sfab_pkg::DIM_W-1:0]  WIDTH_AT_RESET  = 13'd640;
    localparam logic [sfab_pkg::DIM_W-1:0]  HEIGHT_AT_RESET = 13'd480;
    localparam logic [sfab_pkg::BAND_W-1:0] BAND_AT_RESET   = 8'd8;

    logic [sfab_pkg::DIM_W-1:0]  width_reg;
    logic [sfab_pkg::DIM_W-1:0]  height_reg;
    logic [sfab_pkg::BAND_W-1:0] band_reg;

    sfab_pkg::pix_out_t expected_pixels[$];

    // Feather weight along one axis; pos is already known to lie inside size.
    function automatic longint unsigned seam_weight(longint unsigned pos,
                                                    longint unsigned size,
                                                    longint unsigned req_band);
        longint unsigned band;
        longint unsigned gap;
        band = size / 2;
        if (req_band < band)
            band = req_band;
        if (band == 0)
            return ALPHA_ONE;
        gap = size - pos;
        if (gap > band)
            return ALPHA_ONE;
        return (gap * ALPHA_ONE + band / 2) / band;
    endfunction

    function automatic logic [sfab_pkg::CH_W-1:0] blend_channel(
        longint unsigned alpha,
        longint unsigned tile_ch,
        longint unsigned mos_ch);
        longint unsigned from_tile;
        longint unsigned from_mosaic;
        longint unsigned sum;
        from_tile   = (alpha * tile_ch + ALPHA_HALF) >> ALPHA_FRAC_BITS;
        from_mosaic = ((ALPHA_ONE - alpha) * mos_ch + ALPHA_HALF) >> ALPHA_FRAC_BITS;
        sum = from_tile + from_mosaic;
        return (sum > 255) ? 8'd255 : sum[sfab_pkg::CH_W-1:0];
    endfunction

    function automatic sfab_pkg::pix_out_t blend_pixel(sfab_pkg::pix_in_t px);
        longint unsigned w;
        longint unsigned h;
        longint unsigned alpha;
        longint unsigned alpha_y;
        sfab_pkg::pix_out_t r;
        w = 64'(width_reg);
        h = 64'(height_reg);
        if (w > DIM_LIMIT)
            w = DIM_LIMIT;
        if (h > DIM_LIMIT)
            h = DIM_LIMIT;
        if (64'(px.pixel_col) >= w || 64'(px.pixel_row) >= h)
        begin
            // Nothing is written outside the region: the mosaic stays.
            r.out_blue  = px.mosaic_blue;
            r.out_green = px.mosaic_green;
            r.out_red   = px.mosaic_red;
        end
        else if (band_reg == '0)
        begin
            r.out_blue  = px.tile_blue;
            r.out_green = px.tile_green;
            r.out_red   = px.tile_red;
        end
        else
        begin
            alpha   = seam_weight(64'(px.pixel_col), w, 64'(band_reg));
            alpha_y = seam_weight(64'(px.pixel_row), h, 64'(band_reg));
            if (alpha_y < alpha)
                alpha = alpha_y;
            r.out_blue  = blend_channel(alpha, 64'(px.tile_blue), 64'(px.mosaic_blue));
            r.out_green = blend_channel(alpha, 64'(px.tile_green), 64'(px.mosaic_green));
            r.out_red   = blend_channel(alpha, 64'(px.tile_red), 64'(px.mosaic_red));
        end
        return r;
    endfunction

    task automatic check_channel(input string name,
                                 input logic [sfab_pkg::CH_W-1:0] want,
                                 input logic [sfab_pkg::CH_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // A pixel accepted at the same edge as a register write still sees the
    // old register values, so the prediction comes first.
    always @(posedge clk or negedge rst_n)
    begin
        sfab_pkg::pix_out_t want;
        if (!rst_n)
        begin
            width_reg  = WIDTH_AT_RESET;
            height_reg = HEIGHT_AT_RESET;
            band_reg   = BAND_AT_RESET;
            fail_count = 0;
            expected_pixels.delete();
            pending <= 0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
                expected_pixels.insert(expected_pixels.size(), blend_pixel(pixel));
            if (cfg_valid && cfg_ready)
            begin
                case (sfab_pkg::cfg_idx_t'(cfg_index))
                    sfab_pkg::CFG_REGION_WIDTH:
                        width_reg  = cfg_data[sfab_pkg::DIM_W-1:0];
                    sfab_pkg::CFG_REGION_HEIGHT:
                        height_reg = cfg_data[sfab_pkg::DIM_W-1:0];
                    sfab_pkg::CFG_BLEND_BAND:
                        band_reg   = cfg_data[sfab_pkg::BAND_W-1:0];
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result word with no pending expectation: %0d %0d %0d",
                           result.out_blue, result.out_green, result.out_red);
                    fail_count++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_channel("out_blue", want.out_blue, result.out_blue);
                    check_channel("out_green", want.out_green, result.out_green);
                    check_channel("out_red", want.out_red, result.out_red);
                end
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the seam feather alpha blend core
// Streams pixel words through the core under several region and band
// settings, with random gaps on the sender and random stalls on the receiver,
// while a separate checker predicts and compares every blended pixel.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ALPHA_FRAC_BITS = 16;

    // A settling stretch longer than the core is deep is allowed to pass before
    // registers change and before the verdict, so that a stray extra result word
    // would still be caught.
    localparam int SETTLE_CYCLES = 16;

    // Longest stretch of cycles without any accepted word before the run is
    // declared hung. A correct run never comes near this.
    localparam int QUIET_LIMIT = 2000;

    // Register index that maps to no register; writes to it must be ignored.
    localparam logic [sfab_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef logic [sfab_pkg::CFG_DATA_W-1:0] cfg_word_t;
    typedef logic [sfab_pkg::POS_W-1:0]      pos_t;
    typedef logic [sfab_pkg::CH_W-1:0]       chan_t;
    typedef logic [sfab_pkg::BAND_W-1:0]     band_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            pixel_valid;
    logic                            pixel_stall;
    sfab_pkg::pix_in_t               pixel;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    sfab_pkg::pix_out_t              result;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [sfab_pkg::CFG_IDX_W-1:0]  cfg_index;
    cfg_word_t                       cfg_data;

    int fail_count;
    int pending;
    int quiet_cycles = 0;

    // Idle rates in percent, changed by the stimulus between phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    seam_feather_alpha_blend_core #(
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    sfab_checker #(
        .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // The receiver stalls at random, one fresh decision per cycle.
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Hang detection: any accepted word on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // A pixel word is packed as position, then tile BGR, then mosaic BGR.
    function automatic sfab_pkg::pix_in_t make_pix(pos_t col, pos_t row,
                                                   logic [23:0] tile_bgr,
                                                   logic [23:0] mosaic_bgr);
        return {col, row, tile_bgr, mosaic_bgr};
    endfunction

    // Register writes leave the valid high; the caller lowers it after the
    // last write of a batch so that back-to-back writes never drop it.
    task automatic write_reg(input logic [sfab_pkg::CFG_IDX_W-1:0] idx,
                             input cfg_word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input cfg_word_t width_data,
                                input cfg_word_t height_data,
                                input cfg_word_t band_data);
        write_reg(sfab_pkg::CFG_REGION_WIDTH, width_data);
        write_reg(sfab_pkg::CFG_REGION_HEIGHT, height_data);
        write_reg(sfab_pkg::CFG_BLEND_BAND, band_data);
        cfg_valid <= 1'b0;
    endtask

    // Sends one pixel word, with a random run of idle cycles in front of it.
    // The valid stays high afterwards so a following word goes out at once.
    task automatic send_pixel(input sfab_pkg::pix_in_t px);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
    endtask

    // Ends a phase: the sender goes quiet, every expected word has to come
    // back, then the pipeline gets some extra cycles before anything changes.
    // The first edge lets the checker count the word accepted last.
    task automatic finish_phase();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Region dimensions: mostly small so that the seam bands cover a good
    // share of the pixels, with the odd huge, oversized or empty region.
    function automatic cfg_word_t pick_dim();
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (sel < 10)
            return cfg_word_t'($urandom_range(3, 1));
        else if (sel < 55)
            return cfg_word_t'($urandom_range(64, 4));
        else if (sel < 75)
            return cfg_word_t'($urandom_range(4095, 65));
        else if (sel < 85)
            return cfg_word_t'(sfab_pkg::MAX_DIM);
        else if (sel < 95)
            return cfg_word_t'($urandom_range(8191, sfab_pkg::MAX_DIM + 1));
        else
            return '0;
    endfunction

    function automatic band_t pick_band();
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (sel < 10)
            return '0;
        else if (sel < 20)
            return 8'd255;
        else if (sel < 30)
            return 8'd1;
        else
            return band_t'($urandom_range(32, 2));
    endfunction

    // Position along one axis: many land in or near the seam band, some
    // anywhere inside, some outside the region and some fully random.
    function automatic pos_t pick_pos(int unsigned size, int unsigned reach);
        int unsigned sel;
        int unsigned span;
        sel = $urandom_range(99, 0);
        if (size == 0 || sel < 8)
            return pos_t'($urandom_range(4095, 0));
        if (sel < 16 && size <= 4095)
            return pos_t'($urandom_range(4095, size));
        if (sel < 60)
        begin
            span = (reach < size - 1) ? reach : size - 1;
            return pos_t'(size - 1 - $urandom_range(span, 0));
        end
        return pos_t'($urandom_range(size - 1, 0));
    endfunction

    function automatic chan_t pick_chan();
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (sel < 15)
            return '0;
        else if (sel < 30)
            return 8'd255;
        else
            return chan_t'($urandom_range(255, 0));
    endfunction

    initial
    begin
        cfg_word_t             width_data;
        cfg_word_t             height_data;
        band_t                 band;
        cfg_word_t             band_data;
        int unsigned           eff_width;
        int unsigned           eff_height;
        int unsigned           count;
        sfab_pkg::pix_in_t     px;

        rst_n       <= 1'b0;
        pixel_valid <= 1'b0;
        pixel       <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= sfab_pkg::CFG_REGION_WIDTH;
        cfg_data    <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 32;
        recv_stall_pct = 46;

        // Directed part, first under the values loaded at reset (640 x 480,
        // band of 8): interior, the last column and row, and positions past
        // the region including the largest ones.
        send_pixel(make_pix(12'd0, 12'd0, 24'hFFFFFF, 24'h000000));
        send_pixel(make_pix(12'd639, 12'd0, 24'hFF8001, 24'h00FF7E));
        send_pixel(make_pix(12'd632, 12'd479, 24'h123456, 24'hFEDCBA));
        send_pixel(make_pix(12'd640, 12'd0, 24'hAAAAAA, 24'h555555));
        send_pixel(make_pix(12'd0, 12'd480, 24'h0F0F0F, 24'hF0F0F0));
        send_pixel(make_pix(12'd4095, 12'd4095, 24'h000000, 24'hFFFFFF));
        finish_phase();

        // A write to the unmapped index must leave everything alone. Then an
        // oversized width, taken as the largest dimension, and a band of zero
        // (with junk above the band bits) that turns the blend into a copy.
        write_reg(CFG_UNUSED, 13'h1FFF);
        program_regs(13'h1FFF, 13'd4096, 13'h1F00);
        send_pixel(make_pix(12'd4095, 12'd4095, 24'h0180FF, 24'hFE7F00));
        send_pixel(make_pix(12'd0, 12'd0, 24'h00FF00, 24'hFF00FF));
        finish_phase();

        // Widest band: the thinnest nonzero weight at the corner, and the
        // points where the ramp meets full weight.
        program_regs(13'h1FFF, 13'd4096, 13'd255);
        send_pixel(make_pix(12'd4095, 12'd4095, 24'hFFFFFF, 24'h000000));
        send_pixel(make_pix(12'd3841, 12'd100, 24'h80FF01, 24'h7F00FE));
        send_pixel(make_pix(12'd3840, 12'd4000, 24'h336699, 24'hCC9966));
        finish_phase();

        // Tiny region: half weight with white on white rounds up past 255
        // and has to saturate.
        program_regs(13'd4, 13'd4, 13'd2);
        send_pixel(make_pix(12'd3, 12'd0, 24'hFFFFFF, 24'hFFFFFF));
        send_pixel(make_pix(12'd3, 12'd3, 24'hFF00FF, 24'h00FF00));
        send_pixel(make_pix(12'd2, 12'd3, 24'h010203, 24'hFDFEFF));
        send_pixel(make_pix(12'd4, 12'd0, 24'h111111, 24'hEEEEEE));
        finish_phase();

        // One pixel region: too narrow for a band, so the weight stays one.
        program_regs(13'd1, 13'd1, 13'd5);
        send_pixel(make_pix(12'd0, 12'd0, 24'hC0FFEE, 24'h3F0011));
        send_pixel(make_pix(12'd1, 12'd0, 24'hC0FFEE, 24'h3F0011));
        send_pixel(make_pix(12'd0, 12'd1, 24'hC0FFEE, 24'h3F0011));
        finish_phase();

        // Empty region: every position lies outside.
        program_regs(13'd0, 13'd0, 13'd8);
        send_pixel(make_pix(12'd0, 12'd0, 24'hFFFFFF, 24'h123456));
        finish_phase();

        // Random part: three idling modes, ten register settings each.
        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct  = 32;
                    recv_stall_pct = 46;
                end
                1:
                begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 32;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int ph = 0; ph < 10; ph++)
            begin
                width_data  = pick_dim();
                height_data = pick_dim();
                band        = pick_band();
                band_data   = cfg_word_t'(band);
                if ($urandom_range(3, 0) == 0)
                    band_data = band_data |
                                cfg_word_t'($urandom_range(31, 0) << sfab_pkg::BAND_W);
                program_regs(width_data, height_data, band_data);
                eff_width  = 32'(width_data);
                eff_height = 32'(height_data);
                if (eff_width > sfab_pkg::MAX_DIM)
                    eff_width = sfab_pkg::MAX_DIM;
                if (eff_height > sfab_pkg::MAX_DIM)
                    eff_height = sfab_pkg::MAX_DIM;
                count = $urandom_range(80, 40);
                repeat (count)
                begin
                    px.pixel_col    = pick_pos(eff_width, 32'(band) + 2);
                    px.pixel_row    = pick_pos(eff_height, 32'(band) + 2);
                    px.tile_blue    = pick_chan();
                    px.tile_green   = pick_chan();
                    px.tile_red     = pick_chan();
                    px.mosaic_blue  = pick_chan();
                    px.mosaic_green = pick_chan();
                    px.mosaic_red   = pick_chan();
                    send_pixel(px);
                end
                finish_phase();
            end
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
